/* hw/rtl/cnls_pkg.sv */
// ----------------------------------------------------------------------------
// cnls_pkg
// Types, constants and fixed-point helpers of the Crank-Nicolson line solver.
// ----------------------------------------------------------------------------
package cnls_pkg;

    localparam int MaxLen   = 64;
    localparam int AddrW    = 6;
    localparam int CntW     = 7;
    localparam int DivSteps = 48;
    localparam int DivCntW  = 6;

    localparam logic signed [33:0] QOne34 = 34'sd65536;
    localparam logic signed [33:0] QTwo34 = 34'sd131072;
    localparam logic signed [33:0] SatMax = 34'sd2147483647;
    localparam logic signed [33:0] SatMin = -34'sd2147483648;
    localparam logic signed [31:0] QMax   = 32'sh7fffffff;
    localparam logic signed [31:0] QMin   = 32'sh80000000;

    // register indexes (word address)
    localparam logic [1:0] RegHalfDt   = 2'd0;
    localparam logic [1:0] RegSrcScale = 2'd1;
    localparam logic [1:0] RegSrcAct   = 2'd2;
    localparam logic [1:0] RegReflect  = 2'd3;

    typedef struct packed {
        logic signed [31:0] center_coef;
        logic signed [31:0] upper_coef;
        logic signed [31:0] lower_coef;
        logic [30:0]        density;
        logic signed [31:0] source;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [30:0] new_density;
        logic [5:0]  position;
        logic        final_res;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_LD_C, S_LD_U, S_LD_L, S_LD_N, S_LD_S, S_LD_WR,
        S_NB_RD0, S_NB_RD1, S_NB_M1, S_NB_M2,
        S_FW_RD, S_FW_M1, S_FW_M2, S_FW_M3, S_FW_DS1, S_FW_D1, S_FW_DS2, S_FW_D2,
        S_BK_INIT, S_BK_RD, S_BK_M, S_BK_W,
        S_OUT_RD, S_OUT_LD
    } t_state;

    function automatic logic signed [33:0] f_sx34(input logic signed [31:0] v);
        return $signed({{2{v[31]}}, v});
    endfunction

    function automatic logic signed [31:0] f_sat34(input logic signed [33:0] v);
        if (v > SatMax) begin
            return QMax;
        end else if (v < SatMin) begin
            return QMin;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] f_abs33(input logic signed [32:0] v);
        logic signed [32:0] t;
        t = (v < 0) ? -v : v;
        return t[31:0];
    endfunction

    // round half away from zero, clamp magnitude to 2^31, apply sign, saturate
    function automatic logic signed [31:0] f_qmul_post(input logic [63:0] prod,
                                                       input logic neg);
        logic [64:0]        sum;
        logic [48:0]        p;
        logic [31:0]        mag;
        logic signed [32:0] t;
        sum = {1'b0, prod} + 65'd32768;
        p   = sum[64:16];
        mag = (p > 49'h0_8000_0000) ? 32'h8000_0000 : p[31:0];
        t   = -$signed({1'b0, mag});
        if (neg) begin
            return t[31:0];
        end
        return mag[31] ? QMax : $signed(mag);
    endfunction

endpackage

/* hw/rtl/crank_nicolson_line_solve_unit.sv */
// ----------------------------------------------------------------------------
// crank_nicolson_line_solve_unit
// One Crank-Nicolson step along a grid line, tridiagonal Thomas solve.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one grid point
//   per transaction. Output channel (o_out_valid / i_out_ready / o_out_data)
//   gives one solved density per point, in order, after the point marked last.
//   The APB port sets half_dt, source_scale, source_active, reflect_first.
// Operation:
//   Loading a point forms five products on the shared multiplier. The solve
//   then computes the neighbour terms, runs forward elimination (two 48-step
//   restoring divisions per point on the shared divider, one on the final
//   point) and back substitution, then gives the results. Up to 64 points;
//   later are dropped.
// Reset:
//   Synchronous, active low. Registers return to their defaults, the point
//   count clears, no output is pending. The coefficient memories are not
//   cleared; only entries of the current line are read.
// Stall:
//   A result waits in the output register while i_out_ready is low; the
//   solver holds until it is taken. The last result may wait while the next
//   line's points are already being loaded.
// ----------------------------------------------------------------------------
module crank_nicolson_line_solve_unit
    import cnls_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration
    logic [31:0] r_half_dt, r_src_scale;
    logic        r_src_act, r_reflect;

    // control
    t_state            r_state, n_state;
    logic [CntW-1:0]   r_count, n_count;
    logic [CntW-1:0]   r_n, n_n;
    logic [AddrW-1:0]  r_i, n_i;
    logic              r_ov, n_ov;

    // datapath registers
    t_in_item           r_in, n_in;
    logic signed [31:0] r_d, n_d, r_up, n_up, r_lo, n_lo;
    logic signed [33:0] r_acc, n_acc;
    logic signed [31:0] r_piv, n_piv, r_prev_sf, n_prev_sf;
    logic signed [31:0] r_prev_rhs, n_prev_rhs, r_x, n_x;
    t_out_item          r_out, n_out;

    // memories
    logic signed [31:0] r_diag_mem [MaxLen];
    logic signed [31:0] r_up_mem   [MaxLen];
    logic signed [31:0] r_lo_mem   [MaxLen];
    logic signed [31:0] r_dens_mem [MaxLen];
    logic signed [31:0] r_rhs_mem  [MaxLen];
    logic signed [31:0] r_sf_mem   [MaxLen];
    logic signed [31:0] r_diag_rd, r_up_rd, r_lo_rd, r_dens_rd, r_rhs_rd, r_sf_rd;
    logic [AddrW-1:0]   ra_main, ra_dens;
    logic               we_ld, we_dens, we_rhs, we_sf;
    logic [AddrW-1:0]   wa_dens, wa_rhs, wa_sf;
    logic signed [31:0] wd_dens, wd_rhs, wd_sf;

    // shared multiplier
    logic signed [32:0] m_a, m_b;
    logic [63:0]        r_prod;
    logic               r_prod_neg;
    logic signed [31:0] q_mul;

    // shared divider
    logic                div_start;
    logic signed [31:0]  div_a, div_m;
    logic [31:0]         div_a_mag, div_m_mag;
    logic [47:0]         r_div_num;
    logic [31:0]         r_div_rem, r_div_den;
    logic [DivCntW-1:0]  r_div_cnt;
    logic                r_div_neg, r_div_zero, r_div_az, r_div_an;
    logic [32:0]         div_rem_sh, div_rem_sub;
    logic                div_bit;
    logic [31:0]         div_mag;
    logic signed [32:0]  div_negq;
    logic signed [31:0]  div_q;

    logic               in_accept, out_accept, not_last_pt, not_first_pt;
    logic signed [31:0] lo_new;

    assign in_accept    = i_in_valid && o_in_ready;
    assign out_accept   = o_out_valid && i_out_ready;
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = r_ov;
    assign o_out_data   = r_out;
    assign not_last_pt  = (({1'b0, r_i} + 7'd1) < r_n);
    assign not_first_pt = (r_i != '0);

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_dt   <= '0;
            r_src_scale <= '0;
            r_src_act   <= 1'b1;
            r_reflect   <= 1'b0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                RegHalfDt:   r_half_dt   <= pwdata;
                RegSrcScale: r_src_scale <= pwdata;
                RegSrcAct:   r_src_act   <= pwdata[0];
                RegReflect:  r_reflect   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            RegHalfDt:   prdata = r_half_dt;
            RegSrcScale: prdata = r_src_scale;
            RegSrcAct:   prdata = {31'd0, r_src_act};
            RegReflect:  prdata = {31'd0, r_reflect};
            default:     prdata = '0;
        endcase
    end

    // ---------------- shared multiplier ----------------
    always_ff @(posedge i_clk) begin
        r_prod     <= f_abs33(m_a) * f_abs33(m_b);
        r_prod_neg <= m_a[32] ^ m_b[32];
    end

    assign q_mul = f_qmul_post(r_prod, r_prod_neg);

    // ---------------- shared divider ----------------
    assign div_a_mag   = f_abs33({div_a[31], div_a});
    assign div_m_mag   = f_abs33({div_m[31], div_m});
    assign div_rem_sh  = {r_div_rem, r_div_num[47]};
    assign div_bit     = (div_rem_sh >= {1'b0, r_div_den});
    assign div_rem_sub = div_rem_sh - {1'b0, r_div_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= DivCntW'(DivSteps);
        end else if (div_start) begin
            r_div_cnt <= '0;
        end else if (r_div_cnt != DivCntW'(DivSteps)) begin
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_div_num  <= {div_a_mag[31:0], 16'd0} + {17'd0, div_m_mag[31:1]};
            r_div_rem  <= '0;
            r_div_den  <= div_m_mag;
            r_div_neg  <= div_a[31] ^ div_m[31];
            r_div_zero <= (div_m == 0);
            r_div_az   <= (div_a == 0);
            r_div_an   <= div_a[31];
        end else if (r_div_cnt != DivCntW'(DivSteps)) begin
            r_div_rem <= div_bit ? div_rem_sub[31:0] : div_rem_sh[31:0];
            r_div_num <= {r_div_num[46:0], div_bit};
        end
    end

    always_comb begin
        div_mag  = (r_div_num > 48'h0000_8000_0000) ? 32'h8000_0000 : r_div_num[31:0];
        div_negq = -$signed({1'b0, div_mag});
        if (r_div_zero) begin
            // zero pivot: saturate toward the numerator's sign, zero for a zero numerator
            div_q = r_div_az ? 32'sd0 : (r_div_an ? QMin : QMax);
        end else if (r_div_neg) begin
            div_q = div_negq[31:0];
        end else begin
            div_q = div_mag[31] ? QMax : $signed(div_mag);
        end
    end

    // ---------------- memories ----------------
    always_ff @(posedge i_clk) begin
        if (we_ld) begin
            r_diag_mem[r_count[AddrW-1:0]] <= r_d;
        end
        r_diag_rd <= r_diag_mem[ra_main];
    end

    always_ff @(posedge i_clk) begin
        if (we_ld) begin
            r_up_mem[r_count[AddrW-1:0]] <= r_up;
        end
        r_up_rd <= r_up_mem[ra_main];
    end

    always_ff @(posedge i_clk) begin
        if (we_ld) begin
            r_lo_mem[r_count[AddrW-1:0]] <= r_lo;
        end
        r_lo_rd <= r_lo_mem[ra_main];
    end

    always_ff @(posedge i_clk) begin
        if (we_dens) begin
            r_dens_mem[wa_dens] <= wd_dens;
        end
        r_dens_rd <= r_dens_mem[ra_dens];
    end

    always_ff @(posedge i_clk) begin
        if (we_rhs) begin
            r_rhs_mem[wa_rhs] <= wd_rhs;
        end
        r_rhs_rd <= r_rhs_mem[ra_main];
    end

    always_ff @(posedge i_clk) begin
        if (we_sf) begin
            r_sf_mem[wa_sf] <= wd_sf;
        end
        r_sf_rd <= r_sf_mem[ra_main];
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_i        <= n_i;
        r_in       <= n_in;
        r_d        <= n_d;
        r_up       <= n_up;
        r_lo       <= n_lo;
        r_acc      <= n_acc;
        r_piv      <= n_piv;
        r_prev_sf  <= n_prev_sf;
        r_prev_rhs <= n_prev_rhs;
        r_x        <= n_x;
        r_out      <= n_out;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_n        = r_n;
        n_i        = r_i;
        n_ov       = r_ov && !out_accept;
        n_in       = r_in;
        n_d        = r_d;
        n_up       = r_up;
        n_lo       = r_lo;
        n_acc      = r_acc;
        n_piv      = r_piv;
        n_prev_sf  = r_prev_sf;
        n_prev_rhs = r_prev_rhs;
        n_x        = r_x;
        n_out      = r_out;

        m_a       = '0;
        m_b       = '0;
        div_start = 1'b0;
        div_a     = '0;
        div_m     = '0;
        ra_main   = r_i;
        ra_dens   = r_i;
        we_ld     = 1'b0;
        we_dens   = 1'b0;
        wa_dens   = r_i;
        wd_dens   = r_x;
        we_rhs    = 1'b0;
        wa_rhs    = r_i;
        wd_rhs    = f_sat34(r_acc);
        we_sf     = 1'b0;
        wa_sf     = r_i;
        wd_sf     = div_q;
        lo_new    = f_sat34(-f_sx34(q_mul));

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_in = i_in_data;
                    if (r_count < CntW'(MaxLen)) begin
                        n_state = S_LD_C;
                    end else if (i_in_data.last) begin
                        // line full: solve what is stored
                        n_n     = r_count;
                        n_count = '0;
                        n_i     = '0;
                        n_state = S_NB_RD0;
                    end
                end
            end
            S_LD_C: begin
                m_a     = {1'b0, r_half_dt};
                m_b     = {r_in.center_coef[31], r_in.center_coef};
                n_state = S_LD_U;
            end
            S_LD_U: begin
                n_d     = f_sat34(QOne34 + f_sx34(q_mul));
                m_a     = {1'b0, r_half_dt};
                m_b     = {r_in.upper_coef[31], r_in.upper_coef};
                n_state = S_LD_L;
            end
            S_LD_L: begin
                n_up    = f_sat34(-f_sx34(q_mul));
                m_a     = {1'b0, r_half_dt};
                m_b     = {r_in.lower_coef[31], r_in.lower_coef};
                n_state = S_LD_N;
            end
            S_LD_N: begin
                n_lo = lo_new;
                if (r_count == '0 && r_reflect) begin
                    n_up = f_sat34(f_sx34(r_up) + f_sx34(lo_new));
                end
                m_a     = {2'b00, r_in.density};
                m_b     = {r_d[31], f_sat34(QTwo34 - f_sx34(r_d))};
                m_b     = $signed({m_b[31], m_b[31:0]});
                n_state = S_LD_S;
            end
            S_LD_S: begin
                n_acc   = f_sx34(q_mul);
                m_a     = {1'b0, r_src_scale};
                m_b     = {r_in.source[31], r_in.source};
                n_state = S_LD_WR;
            end
            S_LD_WR: begin
                we_ld   = 1'b1;
                we_dens = 1'b1;
                wa_dens = r_count[AddrW-1:0];
                wd_dens = $signed({1'b0, r_in.density});
                we_rhs  = 1'b1;
                wa_rhs  = r_count[AddrW-1:0];
                wd_rhs  = f_sat34(r_acc + (r_src_act ? f_sx34(q_mul) : 34'sd0));
                n_count = r_count + 1'b1;
                if (r_in.last) begin
                    n_n     = r_count + 1'b1;
                    n_count = '0;
                    n_i     = '0;
                    n_state = S_NB_RD0;
                end else begin
                    n_state = S_IDLE;
                end
            end
            // neighbour terms of the right side, written back in place
            S_NB_RD0: begin
                ra_dens = r_i + 1'b1;
                n_state = S_NB_RD1;
            end
            S_NB_RD1: begin
                ra_dens = r_i - 1'b1;
                n_acc   = f_sx34(r_rhs_rd);
                m_a     = {r_dens_rd[31], r_dens_rd};
                m_b     = {r_up_rd[31], r_up_rd};
                n_state = S_NB_M1;
            end
            S_NB_M1: begin
                if (not_last_pt) begin
                    n_acc = r_acc - f_sx34(q_mul);
                end
                m_a     = {r_dens_rd[31], r_dens_rd};
                m_b     = {r_lo_rd[31], r_lo_rd};
                n_state = S_NB_M2;
            end
            S_NB_M2: begin
                we_rhs = 1'b1;
                wd_rhs = f_sat34(r_acc - (not_first_pt ? f_sx34(q_mul) : 34'sd0));
                if (not_last_pt) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_NB_RD0;
                end else begin
                    n_i     = '0;
                    n_state = S_FW_RD;
                end
            end
            // forward elimination
            S_FW_RD: begin
                n_state = S_FW_M1;
            end
            S_FW_M1: begin
                n_piv   = r_diag_rd;
                n_acc   = f_sx34(r_rhs_rd);
                n_up    = r_up_rd;
                m_a     = {r_lo_rd[31], r_lo_rd};
                m_b     = {r_prev_sf[31], r_prev_sf};
                n_state = S_FW_M2;
            end
            S_FW_M2: begin
                if (not_first_pt) begin
                    n_piv = f_sat34(f_sx34(r_piv) - f_sx34(q_mul));
                end
                m_a     = {r_lo_rd[31], r_lo_rd};
                m_b     = {r_prev_rhs[31], r_prev_rhs};
                n_state = S_FW_M3;
            end
            S_FW_M3: begin
                if (not_first_pt) begin
                    n_acc = r_acc - f_sx34(q_mul);
                end
                n_state = S_FW_DS1;
            end
            S_FW_DS1: begin
                if (not_last_pt) begin
                    div_start = 1'b1;
                    div_a     = r_up;
                    div_m     = r_piv;
                    n_state   = S_FW_D1;
                end else begin
                    we_sf     = 1'b1;
                    wd_sf     = '0;
                    n_prev_sf = '0;
                    n_state   = S_FW_DS2;
                end
            end
            S_FW_D1: begin
                if (r_div_cnt == DivCntW'(DivSteps)) begin
                    we_sf     = 1'b1;
                    n_prev_sf = div_q;
                    n_state   = S_FW_DS2;
                end
            end
            S_FW_DS2: begin
                div_start = 1'b1;
                div_a     = f_sat34(r_acc);
                div_m     = r_piv;
                n_state   = S_FW_D2;
            end
            S_FW_D2: begin
                if (r_div_cnt == DivCntW'(DivSteps)) begin
                    we_rhs     = 1'b1;
                    wd_rhs     = div_q;
                    n_prev_rhs = div_q;
                    if (not_last_pt) begin
                        n_i     = r_i + 1'b1;
                        n_state = S_FW_RD;
                    end else begin
                        n_state = S_BK_INIT;
                    end
                end
            end
            // back substitution, solution goes to the density memory
            S_BK_INIT: begin
                we_dens = 1'b1;
                wd_dens = r_prev_rhs;
                n_x     = r_prev_rhs;
                n_state = (r_i == '0) ? S_OUT_RD : S_BK_RD;
            end
            S_BK_RD: begin
                ra_main = r_i - 1'b1;
                n_state = S_BK_M;
            end
            S_BK_M: begin
                n_acc   = f_sx34(r_rhs_rd);
                m_a     = {r_sf_rd[31], r_sf_rd};
                m_b     = {r_x[31], r_x};
                n_state = S_BK_W;
            end
            S_BK_W: begin
                we_dens = 1'b1;
                wa_dens = r_i - 1'b1;
                wd_dens = f_sat34(r_acc - f_sx34(q_mul));
                n_x     = wd_dens;
                n_i     = r_i - 1'b1;
                n_state = (r_i == AddrW'(1)) ? S_OUT_RD : S_BK_RD;
            end
            // results in point order
            S_OUT_RD: begin
                if (!r_ov || out_accept) begin
                    n_state = S_OUT_LD;
                end
            end
            S_OUT_LD: begin
                n_out.new_density = (r_dens_rd > 0) ? r_dens_rd[30:0] : 31'd0;
                n_out.position    = r_i;
                n_out.final_res   = !not_last_pt;
                n_ov              = 1'b1;
                if (not_last_pt) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_OUT_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

/* bench/crank_nicolson_line_solve_unit_tb.sv */
// ----------------------------------------------------------------------------
// crank_nicolson_line_solve_unit_tb
// Self-checking bench for the Crank-Nicolson line solver.
// Grid points go in over a valid/ready channel. A bit-exact Q16.16 model
// predicts the solved densities of every line, and each result is compared
// in order. Directed lines cover the field extremes, zero pivots, single
// points, reflect mode and overlong lines. Random lines run under several
// register settings and idle patterns, and one long output hold fills the
// block up.
// ----------------------------------------------------------------------------
module crank_nicolson_line_solve_unit_tb;
    import cnls_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WatchdogLimit = 60000;
    localparam int DrainCycles   = 60;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    crank_nicolson_line_solve_unit dut (.*);

    // shadow registers and line stores of the predictor
    logic [31:0] cfg_half_dt;
    logic [31:0] cfg_src_scale;
    logic        cfg_src_act;
    logic        cfg_reflect;

    int          diag_q [MaxLen];
    int          upper_q[MaxLen];
    int          lower_q[MaxLen];
    int          dens_q [MaxLen];
    int          rhs_q  [MaxLen];
    int          sweep_q[MaxLen];
    int          points_held;

    t_out_item   expected_densities[$];
    int          errors;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          recv_hold_left;
    int          quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // fixed-point arithmetic of the predictor
    // ------------------------------------------------------------------
    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return int'(v);
    endfunction

    function automatic int fx_mul(longint a, longint b);
        bit               neg;
        longint unsigned  ma, mb, p;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? -a : a;
        mb  = (b < 0) ? -b : b;
        p   = (ma * mb + 64'd32768) >> 16;
        if (p > 64'h8000_0000) p = 64'h8000_0000;
        return sat32(neg ? -longint'(p) : longint'(p));
    endfunction

    function automatic int fx_div(int a, int m);
        bit               neg;
        longint unsigned  ma, mm, q;
        if (m == 0) begin
            if (a == 0) return 0;
            return (a > 0) ? 32'h7fffffff : 32'h80000000;
        end
        neg = (a < 0) != (m < 0);
        ma  = (a < 0) ? -longint'(a) : longint'(a);
        mm  = (m < 0) ? -longint'(m) : longint'(m);
        q   = ((ma << 16) + (mm >> 1)) / mm;
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return sat32(neg ? -longint'(q) : longint'(q));
    endfunction

    // builds one row, and on the last point solves the line
    task automatic predict_line_step(input t_in_item it);
        longint    h, r;
        int        d, up, lo, nd, n, piv;
        t_out_item res;
        h = longint'(cfg_half_dt);
        if (points_held < MaxLen) begin
            nd = int'({1'b0, it.density});
            d  = sat32(64'sd65536 + fx_mul(h, it.center_coef));
            up = sat32(-longint'(fx_mul(h, it.upper_coef)));
            lo = sat32(-longint'(fx_mul(h, it.lower_coef)));
            if (points_held == 0 && cfg_reflect) up = sat32(longint'(up) + lo);
            r = fx_mul(nd, sat32(64'sd131072 - d));
            if (cfg_src_act) r += fx_mul(longint'(cfg_src_scale), it.source);
            diag_q[points_held]  = d;
            upper_q[points_held] = up;
            lower_q[points_held] = lo;
            dens_q[points_held]  = nd;
            rhs_q[points_held]   = sat32(r);
            points_held++;
        end
        if (!it.last) return;
        n = points_held;
        points_held = 0;
        if (n == 0) return;

        for (int i = 0; i < n; i++) begin
            r = rhs_q[i];
            if (i + 1 < n) r -= fx_mul(dens_q[i + 1], upper_q[i]);
            if (i > 0) r -= fx_mul(dens_q[i - 1], lower_q[i]);
            sweep_q[i] = sat32(r);
        end
        for (int i = 0; i < n; i++) rhs_q[i] = sweep_q[i];

        // forward elimination
        for (int i = 0; i < n; i++) begin
            r = rhs_q[i];
            if (i == 0) begin
                piv = diag_q[0];
            end else begin
                piv = sat32(longint'(diag_q[i]) - fx_mul(lower_q[i], sweep_q[i - 1]));
                r -= fx_mul(lower_q[i], rhs_q[i - 1]);
            end
            sweep_q[i] = (i + 1 < n) ? fx_div(upper_q[i], piv) : 0;
            rhs_q[i]   = fx_div(sat32(r), piv);
        end

        // back substitution
        dens_q[n - 1] = rhs_q[n - 1];
        for (int i = n - 1; i > 0; i--) begin
            dens_q[i - 1] = sat32(longint'(rhs_q[i - 1]) - fx_mul(sweep_q[i - 1], dens_q[i]));
        end

        for (int i = 0; i < n; i++) begin
            res.new_density = (dens_q[i] > 0) ? dens_q[i][30:0] : '0;
            res.position    = i[5:0];
            res.final_res   = (i + 1 == n);
            expected_densities = {expected_densities, res};
        end
    endtask

    // ------------------------------------------------------------------
    // channel drivers
    // ------------------------------------------------------------------
    task automatic send_point(input t_in_item it);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_line_step(it);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            RegHalfDt:   cfg_half_dt   = value;
            RegSrcScale: cfg_src_scale = value;
            RegSrcAct:   cfg_src_act   = value[0];
            RegReflect:  cfg_reflect   = value[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [31:0] h, input logic [31:0] ss,
                            input logic act, input logic refl);
        reg_write(RegHalfDt, h);
        reg_write(RegSrcScale, ss);
        reg_write(RegSrcAct, {31'd0, act});
        reg_write(RegReflect, {31'd0, refl});
    endtask

    // lets every expected result arrive, then lets the solver settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_densities.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic t_in_item rand_point(input bit wide, input bit last);
        t_in_item it;
        if (wide) begin
            it.center_coef = $urandom;
            it.upper_coef  = $urandom;
            it.lower_coef  = $urandom;
            it.source      = $urandom;
            it.density     = 31'($urandom);
        end else begin
            it.center_coef = $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
            it.upper_coef  = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            it.lower_coef  = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            it.source      = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            it.density     = 31'($urandom_range(0, 32'h0100_0000));
        end
        it.last = last;
        return it;
    endfunction

    task automatic send_line(input int len, input int wide_pct);
        for (int i = 0; i < len; i++) begin
            send_point(rand_point($urandom_range(99) < wide_pct, i == len - 1));
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_field_extremes();
        t_in_item it;
        set_regs(32'h0000_8000, 32'h0001_0000, 1'b1, 1'b0);
        it = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff,
               32'sh80000000, 1'b0};
        send_point(it);
        it = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000, 31'h0,
               32'sh7fffffff, 1'b0};
        send_point(it);
        it = '{32'sh0, 32'sh0, 32'sh0, 31'h7fffffff, 32'sh0, 1'b1};
        send_point(it);
        wait_idle();
        set_regs(32'hffff_ffff, 32'hffff_ffff, 1'b1, 1'b1);
        it = '{32'shffffffff, 32'shffffffff, 32'shffffffff, 31'h7fffffff,
               32'shffffffff, 1'b0};
        send_point(it);
        it = '{32'sh7fffffff, 32'sh80000000, 32'sh00010000, 31'h1, 32'sh1, 1'b1};
        send_point(it);
        wait_idle();
    endtask

    task automatic test_single_points();
        t_in_item it;
        // reflect on: the folded upper of a lone row goes unused
        set_regs(32'h0000_4000, 32'h0000_0000, 1'b0, 1'b1);
        it = rand_point(1'b0, 1'b1);
        send_point(it);
        wait_idle();
        set_regs(32'h0000_0000, 32'h0002_0000, 1'b1, 1'b0);
        it = rand_point(1'b1, 1'b1);
        send_point(it);
        wait_idle();
    endtask

    task automatic test_zero_pivot();
        t_in_item it;
        // h = 1.0, c = -1.0 gives a zero diagonal
        set_regs(32'h0001_0000, 32'h0001_0000, 1'b1, 1'b0);
        it = '{-32'sh0001_0000, 32'sh0, 32'sh0, 31'h0, 32'sh0, 1'b1};
        send_point(it);
        it = '{-32'sh0001_0000, 32'sh0, 32'sh0, 31'h0, 32'sh0001_0000, 1'b1};
        send_point(it);
        it = '{-32'sh0001_0000, 32'sh0, 32'sh0, 31'h0, -32'sh0001_0000, 1'b1};
        send_point(it);
        it = '{-32'sh0001_0000, 32'sh0001_0000, 32'sh0, 31'h0001_0000, 32'sh0, 1'b0};
        send_point(it);
        it = '{32'sh0, 32'sh0, 32'sh0001_0000, 31'h0002_0000, 32'sh0, 1'b1};
        send_point(it);
        wait_idle();
    endtask

    task automatic test_overlong_line();
        set_regs(32'h0000_2000, 32'h0000_1000, 1'b1, 1'b1);
        // points past the store limit are dropped, last still solves
        send_line(MaxLen + 3, 10);
        wait_idle();
    endtask

    task automatic test_random_lines(input int items, input int idle, input int stall,
                                     input int wide_pct);
        int sent;
        int len;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        sent = 0;
        while (sent < items) begin
            case ($urandom_range(9))
                0:       len = $urandom_range(1, 2);
                1:       len = $urandom_range(13, 24);
                default: len = $urandom_range(3, 12);
            endcase
            send_line(len, wide_pct);
            sent += len;
        end
        wait_idle();
    endtask

    task automatic test_output_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_regs(32'h0000_3000, 32'h0000_8000, 1'b1, 1'b0);
        recv_hold_left = 3000;
        send_line(4, 0);
        send_line(5, 0);
        send_line(3, 0);
        wait_idle();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        errors         = 0;
        points_held    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold_left = 0;
        cfg_half_dt    = '0;
        cfg_src_scale  = '0;
        cfg_src_act    = 1'b1;
        cfg_reflect    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_single_points();
        test_zero_pivot();
        test_overlong_line();

        set_regs(32'h0000_2000, 32'h0000_4000, 1'b1, 1'b0);
        test_random_lines(40, 0, 0, 10);
        set_regs(32'h0000_8000, 32'h0001_0000, 1'b1, 1'b1);
        test_random_lines(40, 61, 0, 10);
        set_regs($urandom, $urandom, 1'b0, 1'b0);
        test_random_lines(40, 0, 61, 40);
        set_regs(32'h0000_1000, 32'h0000_0100, 1'b1, 1'b1);
        test_random_lines(40, 15, 15, 10);
        set_regs(32'hffff_ffff, 32'h0000_0000, 1'b0, 1'b1);
        test_random_lines(25, 15, 15, 50);
        test_output_hold();

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // receiver: random stalls, one long hold, in-order compare
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_densities.size() == 0) begin
                    $display("%t unexpected result: got %p", $realtime, o_out_data);
                    errors++;
                end else begin
                    want = expected_densities.pop_front();
                    if (o_out_data.new_density !== want.new_density ||
                        o_out_data.position !== want.position ||
                        o_out_data.final_res !== want.final_res) begin
                        $display("%t mismatch: expected %p actual %p",
                                 $realtime, want, o_out_data);
                        errors++;
                    end
                end
            end
            if (recv_hold_left > 0) begin
                recv_hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || psel ||
            !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WatchdogLimit) begin
            $display("%t watchdog expired", $realtime);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

/* filelist.f */
hw/rtl/cnls_pkg.sv
hw/rtl/crank_nicolson_line_solve_unit.sv
bench/crank_nicolson_line_solve_unit_tb.sv
